[rtl/core/ilir_pkg.sv]
// Shared constants, codes and the cell command type of the indexed list.
package ilir_pkg;

  localparam int CAPACITY = 64;
  localparam int IDXW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int POSW     = 7;
  localparam int VALW     = 32;
  localparam int PCW_A    = (POSW > CW) ? POSW : CW;
  localparam int PCW      = (PCW_A > IDXW) ? PCW_A : IDXW;
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Command broadcast to every cell in the accept cycle.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              rd;
    logic [PCW-1:0]    pos;
    logic [VALW-1:0]   value;
  } ilir_cmd_t;

endpackage

[rtl/core/indexed_list_insert_remove.sv]
// Top level of the indexed list: control, count, cell row and result register.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a row of
// cells. Each input word asks to insert new_value at a position (0 up to
// the count), remove the value at a position, or read it (below the count).
// Every input word gives exactly one output word with status, read value
// and the count after the operation.
// Input channel: in_tvalid/in_tready/in_tdata, one word per operation.
// Output channel: out_tvalid/out_tready/out_tdata, one word per result.
// Timing: insert, remove and rejected requests show their result in the
// cycle after acceptance; a read in range goes first through the registered
// OR tree that collects the selected cell, then into the result register.
// Throughput: one word per cycle for insert and remove while the output is
// not stalled; a read blocks the input until its result leaves the tree.
// Every cell compares its slot index with the position and takes its left
// neighbor, its right neighbor or the new value, so the whole shift is done
// in the accept cycle.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; cell contents are left as they are and never read before written.
// When the receiver stalls, the result is held in the output register and
// the input stalls too once a further result would have nowhere to go.
module indexed_list_insert_remove import ilir_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [1:0] kind, [8:2] position, [40:9] new_value, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [1:0] status, [33:2] read_value, [40:34] count_after
);

  typedef enum logic {
    S_IDLE,
    S_RD
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic            out_valid_r;
  status_t         out_status_r;
  logic [VALW-1:0] out_value_r;
  logic [CW-1:0]   out_count_r;

  kind_t           in_kind;
  logic [POSW-1:0] in_pos;
  logic [VALW-1:0] in_val;
  logic [PCW-1:0]  pos_x;
  logic [PCW-1:0]  cnt_x;
  logic            out_free;
  logic            accept;
  logic            out_load;
  logic            is_full;
  status_t         imm_status;
  logic            rd_ok;
  ilir_cmd_t       cmd;

  logic [VALW-1:0] cell_val [CAPACITY];
  logic [VALW-1:0] cell_rd  [CAPACITY];
  logic [VALW-1:0] rd_word;

  // Unpack the input word.
  assign in_kind = kind_t'(in_tdata[1:0]);
  assign in_pos  = in_tdata[8:2];
  assign in_val  = in_tdata[40:9];

  assign pos_x   = PCW'(in_pos);
  assign cnt_x   = PCW'(count_r);
  assign is_full = (cnt_x == PCW'(CAPACITY));

  // Take a new word only when a result slot is free this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // Load the result register straight from the input or from the read tree.
  assign out_load = (state_r == S_IDLE) ? (accept && !rd_ok) : out_free;

  // Decide the status of the word at the input.
  always_comb begin
    imm_status = ST_RANGE;
    rd_ok      = 1'b0;
    unique case (in_kind)
      KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          imm_status = ST_RANGE;
        end else if (is_full) begin
          imm_status = ST_FULL;
        end else begin
          imm_status = ST_DONE;
        end
      end
      KIND_REMOVE: begin
        imm_status = (pos_x >= cnt_x) ? ST_RANGE : ST_DONE;
      end
      KIND_READ: begin
        imm_status = (pos_x >= cnt_x) ? ST_RANGE : ST_DONE;
        rd_ok      = (pos_x < cnt_x);
      end
      default: begin
        imm_status = ST_RANGE;
      end
    endcase
  end

  // Broadcast the command to the cell row.
  always_comb begin
    cmd       = '0;
    cmd.ins   = accept && (in_kind == KIND_INSERT) && (imm_status == ST_DONE);
    cmd.rem   = accept && (in_kind == KIND_REMOVE) && (imm_status == ST_DONE);
    cmd.rd    = accept && rd_ok;
    cmd.pos   = pos_x;
    cmd.value = in_val;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALW-1:0] left_v;
    logic [VALW-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g - 1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g + 1];
    end
    ilir_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (IDXW'(g)),
      .left_val  (left_v),
      .right_val (right_v),
      .value     (cell_val[g]),
      .rd_val    (cell_rd[g])
    );
  end

  ilir_rdtree u_rdtree (
    .clk     (clk),
    .load    (cmd.rd),
    .cell_rd (cell_rd),
    .rd_word (rd_word)
  );

  // Sequence control, count and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (rd_ok) begin
              state_r <= S_RD;
            end else begin
              out_status_r <= imm_status;
              out_value_r  <= '0;
              if (cmd.ins) begin
                count_r     <= count_r + 1'b1;
                out_count_r <= count_r + 1'b1;
              end else if (cmd.rem) begin
                count_r     <= count_r - 1'b1;
                out_count_r <= count_r - 1'b1;
              end else begin
                out_count_r <= count_r;
              end
            end
          end
        end
        S_RD: begin
          // Drop the read result in as soon as the slot frees up.
          if (out_free) begin
            state_r      <= S_IDLE;
            out_status_r <= ST_DONE;
            out_value_r  <= rd_word;
            out_count_r  <= count_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, 7'(out_count_r), out_value_r, 2'(out_status_r)};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PCW'(count_r) <= PCW'(CAPACITY))
    else $error("list count exceeds capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("successful insert did not advance the count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (imm_status == ST_FULL) && (in_kind == KIND_INSERT)) |-> is_full)
    else $error("full status without a full list");

  a_rd_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !in_tready)
    else $error("input taken while a read is still in the tree");
`endif

endmodule

[rtl/core/ilir_cell.sv]
// One slot of the list: holds a value, shifts from a neighbor, offers it for read.
module ilir_cell import ilir_pkg::*; (
  input  logic            clk,
  input  ilir_cmd_t       cmd,
  input  logic [IDXW-1:0] idx,
  input  logic [VALW-1:0] left_val,
  input  logic [VALW-1:0] right_val,
  output logic [VALW-1:0] value,
  output logic [VALW-1:0] rd_val
);

  logic [VALW-1:0] value_r;
  logic [VALW-1:0] value_nxt;
  logic [PCW-1:0]  idx_x;

  assign idx_x = PCW'(idx);

  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (idx_x > cmd.pos) begin
        value_nxt = left_val;
      end else if (idx_x == cmd.pos) begin
        value_nxt = cmd.value;
      end
    end else if (cmd.rem && (idx_x >= cmd.pos)) begin
      value_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value  = value_r;
  assign rd_val = (cmd.rd && (idx_x == cmd.pos)) ? value_r : '0;

endmodule

[rtl/core/ilir_rdtree.sv]
// Registered OR tree that gathers the one selected cell value for a read.
module ilir_rdtree import ilir_pkg::*; (
  input  logic            clk,
  input  logic            load,
  input  logic [VALW-1:0] cell_rd [CAPACITY],
  output logic [VALW-1:0] rd_word
);

  logic [VALW-1:0] grp_r   [NGRP];
  logic [VALW-1:0] grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GRP + k];
        end
      end
    end
  end

  // Hold group results until the next read is accepted.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

endmodule
